@@ src/srrw_pkg.sv @@
// ---------------------------------------------------------------------------
// Selective-repeat receive window: shared definitions
// Payload types, codes and the controller/datapath command interface.
// ---------------------------------------------------------------------------
package srrw_pkg;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_CONNECT = 2'd1,
    OP_FINISH  = 2'd2,
    OP_TIMER   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_NAK     = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_FINACK  = 3'd3,
    KIND_GO      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    LINK_IDLE     = 2'd0,
    LINK_WAITDATA = 2'd1,
    LINK_RECV     = 2'd2,
    LINK_WAITRESP = 2'd3
  } link_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sender_address;
    logic [30:0] seq_number;
    logic [15:0] payload_length;
  } srrw_in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] seq_value;
    logic [5:0]         nak_count;
    logic [5:0]         slot_index;
    logic [15:0]        release_length;
    logic [31:0]        reply_address;
    logic               last;
  } srrw_out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_SCAN_START,
    DP_ACK_STEP,
    DP_ACK_PUSH,
    DP_NAK_SKIP,
    DP_NAK_PUSH,
    DP_REL_READ,
    DP_REL_PUSH,
    DP_REL_COMMIT,
    DP_REPLY_PUSH,
    DP_FLUSH
  } dp_cmd_e;

  typedef struct packed {
    logic ack;
    logic rel;
    logic reply;
  } srrw_plan_t;

  typedef struct packed {
    srrw_plan_t plan;
    logic       push_ok;
    logic       pend_empty;
    logic       off_last;
    logic       nak_any;
    logic       nak_end;
    logic       rcv_ptr;
    logic       rel_more;
  } srrw_status_t;

endpackage

@@ src/srrw_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module srrw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/srrw_datapath.sv @@
// ---------------------------------------------------------------------------
// Selective-repeat receive window: datapath
// Link state, window registers, slot scan counters and the result staging.
// ---------------------------------------------------------------------------
module srrw_datapath import srrw_pkg::*; #(
  parameter int WINDOW_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dp_cmd_e      cmd_i,
  output srrw_status_t status_o,
  input  srrw_in_t     in_data_i,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output srrw_out_t    out_data_o
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);

  link_state_e        link_q;
  logic [31:0]        peer_q;
  logic [30:0]        base_q;
  logic [SLOT_W-1:0]  bslot_q;
  logic [7:0]         retry_q, limit_q;
  logic [WINDOW_SLOTS-1:0] rcv_q;
  logic [CNT_W-1:0]   off_q, hi_q, cnt_q;
  logic [SLOT_W-1:0]  ptr_q, ptr_nxt;
  logic               found_q;
  kind_e              reply_kind_q;
  logic [31:0]        reply_addr_q;
  logic               pend_v_q, out_v_q;
  srrw_out_t          pend_q, out_q;

  logic               in_fire, peer_match, in_win, is_top, mark;
  logic [31:0]        diff;
  logic [SLOT_W:0]    slot_sum;
  logic [SLOT_W-1:0]  in_slot;
  srrw_plan_t         plan;
  logic               push, out_free;
  srrw_out_t          res;
  logic [15:0]        rdata;
  logic [31:0]        rel_sum;
  logic [CNT_W-1:0]   holes;

  assign in_fire    = (cmd_i == DP_ACCEPT);
  assign peer_match = (in_data_i.sender_address == peer_q);
  assign diff       = {1'b0, in_data_i.seq_number} - {1'b0, base_q};
  assign in_win     = (diff < 32'(WINDOW_SLOTS));
  assign is_top     = (diff == 32'(WINDOW_SLOTS - 1));
  assign slot_sum   = {1'b0, bslot_q} + {1'b0, diff[SLOT_W-1:0]};
  assign in_slot    = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) ?
                      SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS)) : slot_sum[SLOT_W-1:0];
  assign mark       = (in_data_i.opcode == OP_DATA) && (link_q != LINK_IDLE) &&
                      peer_match && in_win;
  assign ptr_nxt    = (ptr_q == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
  assign rel_sum    = {1'b0, base_q} + 32'(off_q);
  assign holes      = hi_q + 1'b1 - cnt_q;

  // Work that an item calls for, decided from the state before it is applied.
  always_comb begin
    plan = '0;
    case (opcode_e'(in_data_i.opcode))
      OP_TIMER: begin
        case (link_q)
          LINK_WAITDATA: plan.rel = 1'b1;
          LINK_WAITRESP: plan.ack = 1'b1;
          LINK_RECV: begin
            plan.rel = 1'b1;
            plan.ack = (retry_q != limit_q);
          end
          default: plan = '0;
        endcase
      end
      OP_FINISH: begin
        plan.rel   = (link_q != LINK_IDLE) && peer_match;
        plan.reply = 1'b1;
      end
      OP_CONNECT: plan.reply = (link_q == LINK_IDLE);
      default: begin
        plan.reply = (link_q == LINK_IDLE);
        plan.ack   = mark && is_top;
        plan.rel   = mark && is_top;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= LINK_IDLE;
      peer_q  <= '0;
      base_q  <= '0;
      bslot_q <= '0;
      retry_q <= '0;
      limit_q <= 8'd3;
      rcv_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_fire) begin
        case (opcode_e'(in_data_i.opcode))
          OP_TIMER: begin
            case (link_q)
              LINK_WAITDATA: link_q <= LINK_IDLE;
              LINK_WAITRESP: if (retry_q != 8'hFF) retry_q <= retry_q + 1'b1;
              LINK_RECV:     link_q <= (retry_q == limit_q) ? LINK_IDLE : LINK_WAITRESP;
              default:       link_q <= link_q;
            endcase
          end
          OP_FINISH: if (link_q != LINK_IDLE && peer_match) link_q <= LINK_IDLE;
          OP_CONNECT: begin
            if (link_q == LINK_IDLE) begin
              base_q  <= '0;
              bslot_q <= '0;
              rcv_q   <= '0;
              peer_q  <= in_data_i.sender_address;
              link_q  <= LINK_WAITDATA;
            end
          end
          default: begin
            if (mark) begin
              link_q <= LINK_RECV;
              if (link_q != LINK_RECV) retry_q <= '0;
              rcv_q[in_slot] <= 1'b1;
            end
          end
        endcase
      end
      if (cmd_i == DP_REL_PUSH) begin
        rcv_q[ptr_q] <= 1'b0;
      end
      if (cmd_i == DP_REL_COMMIT) begin
        // A wrap of the sequence space can only stop at zero.
        if (rel_sum[31]) begin
          base_q  <= '0;
          bslot_q <= '0;
        end else begin
          base_q  <= rel_sum[30:0];
          bslot_q <= ptr_q;
        end
      end
    end
  end

  // Scan counters and reply capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      reply_addr_q <= in_data_i.sender_address;
      reply_kind_q <= (in_data_i.opcode == OP_CONNECT) ? KIND_GO : KIND_FINACK;
    end
    case (cmd_i)
      DP_SCAN_START: begin
        off_q   <= '0;
        ptr_q   <= bslot_q;
        found_q <= 1'b0;
        hi_q    <= '0;
        cnt_q   <= '0;
      end
      DP_ACK_STEP: begin
        if (rcv_q[ptr_q]) begin
          found_q <= 1'b1;
          hi_q    <= off_q;
          cnt_q   <= cnt_q + 1'b1;
        end
        off_q <= off_q + 1'b1;
        ptr_q <= ptr_nxt;
      end
      DP_ACK_PUSH: begin
        off_q <= '0;
        ptr_q <= bslot_q;
      end
      DP_NAK_SKIP, DP_NAK_PUSH, DP_REL_PUSH: begin
        off_q <= off_q + 1'b1;
        ptr_q <= ptr_nxt;
      end
      default: ;
    endcase
  end

  srrw_ram #(.WIDTH(16), .DEPTH(WINDOW_SLOTS)) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && mark),
    .waddr_i(in_slot),
    .wdata_i(in_data_i.payload_length),
    .re_i   (cmd_i == DP_REL_READ),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // Result formation.
  always_comb begin
    res  = '0;
    push = 1'b1;
    case (cmd_i)
      DP_ACK_PUSH: begin
        res.kind = KIND_ACK;
        if (found_q) begin
          res.seq_value = {1'b0, base_q} + 32'(hi_q);
          res.nak_count = 6'(holes);
        end else begin
          res.seq_value = {1'b0, base_q} - 32'd1;
        end
      end
      DP_NAK_PUSH: begin
        res.kind      = KIND_NAK;
        res.seq_value = {1'b0, base_q} + 32'(off_q);
      end
      DP_REL_PUSH: begin
        res.kind           = KIND_RELEASE;
        res.seq_value      = rel_sum;
        res.slot_index     = 6'(ptr_q);
        res.release_length = rdata;
      end
      DP_REPLY_PUSH: begin
        res.kind          = reply_kind_q;
        res.reply_address = reply_addr_q;
      end
      default: push = 1'b0;
    endcase
  end

  assign out_free = !out_v_q || !out_stall_i;

  // The newest result waits in a staging register until it is known
  // whether another follows, so that the last flag can be set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (push) begin
        if (pend_v_q) begin
          out_v_q <= 1'b1;
        end
        pend_v_q <= 1'b1;
      end else if (cmd_i == DP_FLUSH && pend_v_q && out_free) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (pend_v_q) begin
        out_q <= pend_q;
      end
      pend_q <= res;
    end else if (cmd_i == DP_FLUSH && pend_v_q && out_free) begin
      out_q      <= pend_q;
      out_q.last <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign status_o.plan       = plan;
  assign status_o.push_ok    = !pend_v_q || out_free;
  assign status_o.pend_empty = !pend_v_q;
  assign status_o.off_last   = (off_q == CNT_W'(WINDOW_SLOTS - 1));
  assign status_o.nak_any    = found_q && (hi_q != '0);
  assign status_o.nak_end    = (off_q == hi_q);
  assign status_o.rcv_ptr    = rcv_q[ptr_q];
  assign status_o.rel_more   = (off_q != CNT_W'(WINDOW_SLOTS)) && rcv_q[ptr_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == DP_REL_PUSH) |-> rcv_q[ptr_q])
    else $error("release of a slot that is not marked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(bslot_q) < WINDOW_SLOTS)
    else $error("base slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.opcode == OP_CONNECT && link_q == LINK_IDLE) |=>
    (link_q == LINK_WAITDATA && base_q == '0 && rcv_q == '0))
    else $error("connect did not reset the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && pend_v_q) |-> out_free)
    else $error("staged item overwritten");

endmodule

@@ src/srrw_ctrl.sv @@
// ---------------------------------------------------------------------------
// Selective-repeat receive window: controller
// Sequences the ack, nak, release and reply phases of each item.
// ---------------------------------------------------------------------------
module srrw_ctrl import srrw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  srrw_status_t status_i,
  output dp_cmd_e      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK_START,
    S_ACK_SCAN,
    S_ACK_PUSH,
    S_NAK,
    S_REL_START,
    S_REL_CHK,
    S_REL_EMIT,
    S_REPLY,
    S_FLUSH
  } state_e;

  state_e     state_q, state_d;
  srrw_plan_t plan_q;
  state_e     after_ack, after_rel;

  assign after_rel = plan_q.reply ? S_REPLY : S_FLUSH;
  assign after_ack = plan_q.rel ? S_REL_START : after_rel;

  always_comb begin
    state_d = state_q;
    cmd_o   = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = DP_ACCEPT;
          if (status_i.plan.ack)        state_d = S_ACK_START;
          else if (status_i.plan.rel)   state_d = S_REL_START;
          else if (status_i.plan.reply) state_d = S_REPLY;
          else                          state_d = S_FLUSH;
        end
      end
      S_ACK_START: begin
        cmd_o   = DP_SCAN_START;
        state_d = S_ACK_SCAN;
      end
      S_ACK_SCAN: begin
        cmd_o = DP_ACK_STEP;
        if (status_i.off_last) state_d = S_ACK_PUSH;
      end
      S_ACK_PUSH: begin
        if (status_i.push_ok) begin
          cmd_o   = DP_ACK_PUSH;
          state_d = status_i.nak_any ? S_NAK : after_ack;
        end
      end
      S_NAK: begin
        if (status_i.nak_end) begin
          state_d = after_ack;
        end else if (status_i.rcv_ptr) begin
          cmd_o = DP_NAK_SKIP;
        end else if (status_i.push_ok) begin
          cmd_o = DP_NAK_PUSH;
        end
      end
      S_REL_START: begin
        cmd_o   = DP_SCAN_START;
        state_d = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (status_i.rel_more) begin
          cmd_o   = DP_REL_READ;
          state_d = S_REL_EMIT;
        end else begin
          cmd_o   = DP_REL_COMMIT;
          state_d = after_rel;
        end
      end
      S_REL_EMIT: begin
        if (status_i.push_ok) begin
          cmd_o   = DP_REL_PUSH;
          state_d = S_REL_CHK;
        end
      end
      S_REPLY: begin
        if (status_i.push_ok) begin
          cmd_o   = DP_REPLY_PUSH;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status_i.pend_empty) state_d = S_IDLE;
        else                     cmd_o = DP_FLUSH;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) begin
        plan_q <= status_i.plan;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ src/selective_repeat_receive_window_core.sv @@
// ---------------------------------------------------------------------------
// Selective-repeat receive window core
// Receiver end of a selective-repeat transfer: window tracking and replies.
// ---------------------------------------------------------------------------
// Usage:
// The input channel takes one event item (data, connect, finish or timer)
// with in_valid_i; the block holds in_stall_o high while an item is being
// worked on, so one item is in flight at a time. The output channel emits
// ack, nak, release, go and finack items, the last flagged on each event.
// The configuration channel writes the retry limit and is always ready.
// After the accept, an ack scans every slot; when naks follow, the nak
// pass walks each window offset up to the highest received sequence. A
// release does one length memory read per released slot, then a reply
// follows if one is due. The last result is then handed over by a flush
// before the sequencer returns to idle.
// A stall on the output holds the sequencer at the next result to emit.
// Reset returns the link to idle with an empty window; lengths are kept in
// a memory that needs no clearing since a slot is marked only after write.
// ---------------------------------------------------------------------------
module selective_repeat_receive_window_core import srrw_pkg::*; #(
  parameter int WINDOW_SLOTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  srrw_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output srrw_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  dp_cmd_e      cmd;
  srrw_status_t status;

  assign cfg_ready_o = 1'b1;

  srrw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  srrw_datapath #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ tb/tb_selective_repeat_receive_window_core.sv @@
// ---------------------------------------------------------------------------
// Selective-repeat receive window core: self-checking testbench
// Walks a short table of directed event items, then random traffic made
// mostly of well-formed transfers. Every result is checked against an
// in-bench window model, under several retry limits and idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window_core;
  import srrw_pkg::*;

  localparam int SLOTS = 32;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  srrw_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  srrw_out_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  selective_repeat_receive_window_core #(.WINDOW_SLOTS(SLOTS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Window model state.
  link_state_e m_link;
  logic [31:0] m_peer;
  logic [30:0] m_base;
  logic [7:0]  m_retries;
  logic [7:0]  m_retry_limit;
  bit          m_rcvd [SLOTS];
  logic [15:0] m_len [SLOTS];

  srrw_out_t step_results[$];
  srrw_out_t pending_results[$];
  bit        failed = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_off = 0;

  task automatic emit(kind_e k, logic [31:0] sq, logic [5:0] naks, logic [5:0] slot,
                      logic [15:0] len, logic [31:0] addr);
    srrw_out_t r;
    r = '{kind: k, seq_value: sq, nak_count: naks, slot_index: slot,
          release_length: len, reply_address: addr, last: 1'b0};
    step_results.push_back(r);
  endtask

  task automatic model_ack();
    longint hi;
    bit     found;
    int     holes;
    found = 0;
    hi = 0;
    holes = 0;
    for (int off = 0; off < SLOTS; off++) begin
      if (m_rcvd[(longint'(m_base) + off) % SLOTS]) begin
        hi = longint'(m_base) + off;
        found = 1;
      end
    end
    if (!found) begin
      emit(KIND_ACK, {1'b0, m_base} - 32'd1, '0, '0, '0, '0);
    end else begin
      for (longint q = m_base; q < hi; q++) if (!m_rcvd[q % SLOTS]) holes++;
      emit(KIND_ACK, hi[31:0], holes[5:0], '0, '0, '0);
      for (longint q = m_base; q < hi; q++)
        if (!m_rcvd[q % SLOTS]) emit(KIND_NAK, q[31:0], '0, '0, '0, '0);
    end
  endtask

  task automatic model_release();
    int     off;
    longint q;
    int     s;
    for (off = 0; off < SLOTS; off++) begin
      q = longint'(m_base) + off;
      s = int'(q % SLOTS);
      if (!m_rcvd[s]) break;
      emit(KIND_RELEASE, q[31:0], '0, s[5:0], m_len[s], '0);
      m_rcvd[s] = 0;
    end
    m_base = m_base + off[30:0];
  endtask

  // Works out the results of one accepted item into step_results.
  task automatic model_step(srrw_in_t it);
    longint top;
    int     s;
    step_results.delete();
    case (opcode_e'(it.opcode))
      OP_TIMER: begin
        case (m_link)
          LINK_WAITDATA: begin
            model_release();
            m_link = LINK_IDLE;
          end
          LINK_WAITRESP: begin
            model_ack();
            if (m_retries != 8'hFF) m_retries++;
          end
          LINK_RECV: begin
            if (m_retries == m_retry_limit) begin
              model_release();
              m_link = LINK_IDLE;
            end else begin
              model_ack();
              model_release();
              m_link = LINK_WAITRESP;
            end
          end
          default: ;
        endcase
      end
      OP_FINISH: begin
        if (m_link != LINK_IDLE && it.sender_address == m_peer) begin
          model_release();
          m_link = LINK_IDLE;
        end
        emit(KIND_FINACK, '0, '0, '0, '0, it.sender_address);
      end
      OP_CONNECT: begin
        if (m_link == LINK_IDLE) begin
          m_base = '0;
          foreach (m_rcvd[i]) m_rcvd[i] = 0;
          m_peer = it.sender_address;
          m_link = LINK_WAITDATA;
          emit(KIND_GO, '0, '0, '0, '0, it.sender_address);
        end
      end
      default: begin
        top = longint'(m_base) + SLOTS - 1;
        if (m_link == LINK_IDLE) begin
          emit(KIND_FINACK, '0, '0, '0, '0, it.sender_address);
        end else if (it.sender_address == m_peer && it.seq_number >= m_base &&
                     longint'(it.seq_number) <= top) begin
          if (m_link != LINK_RECV) begin
            m_link = LINK_RECV;
            m_retries = '0;
          end
          s = int'(it.seq_number % SLOTS);
          m_rcvd[s] = 1;
          m_len[s] = it.payload_length;
          if (longint'(it.seq_number) == top) begin
            model_ack();
            model_release();
          end
        end
      end
    endcase
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic send_item(srrw_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_step(it);
  endtask

  // Registers may only change once the block has drained.
  task automatic write_retry_limit(logic [7:0] v);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_retry_limit = v;
  endtask

  function automatic srrw_in_t mk(opcode_e op, logic [31:0] a, logic [30:0] sq,
                                  logic [15:0] len);
    srrw_in_t it;
    it.opcode = op;
    it.sender_address = a;
    it.seq_number = sq;
    it.payload_length = len;
    return it;
  endfunction

  // Random item, biased towards in-window data from the current peer.
  function automatic srrw_in_t random_item();
    int          r;
    logic [31:0] a;
    logic [30:0] sq;
    r = $urandom_range(99);
    a = $urandom;
    sq = 31'($urandom);
    if (m_link == LINK_IDLE) begin
      if (r < 70) begin
        case ($urandom_range(2))
          0: a = '0;
          1: a = '1;
          default: ;
        endcase
        return mk(OP_CONNECT, a, sq, 16'($urandom));
      end
      return mk(opcode_e'($urandom_range(3)), a, sq, 16'($urandom));
    end
    if (r < 62) begin
      sq = m_base + 31'(($urandom_range(99) < 25) ? 31 : $urandom_range(31));
      return mk(OP_DATA, m_peer, sq, 16'($urandom));
    end
    if (r < 76) return mk(OP_TIMER, $urandom, sq, 16'($urandom));
    if (r < 80) return mk(OP_FINISH, m_peer, sq, 16'($urandom));
    if (r < 88) return mk(OP_DATA, ($urandom_range(1) ? m_peer : a), sq, 16'($urandom));
    if (r < 93) return mk(OP_CONNECT, a, sq, 16'($urandom));
    if (r < 96) return mk(OP_FINISH, a, sq, 16'($urandom));
    return mk(OP_DATA, m_peer, m_base + 31'd32 + 31'($urandom_range(40)), 16'($urandom));
  endfunction

  typedef struct {
    srrw_in_t    it;
    bit          typed;
    kind_e       kind;
    logic [31:0] addr;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(srrw_in_t it, bit typed = 0, kind_e k = KIND_ACK,
                         logic [31:0] addr = '0);
    directed_row_t row;
    row = '{it: it, typed: typed, kind: k, addr: addr};
    directed_rows.push_back(row);
  endtask

  localparam logic [31:0] PEER_A = 32'hA5A5_0001;
  localparam logic [31:0] PEER_B = 32'h5A5A_FFFE;

  task automatic run_directed();
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_DATA, '1, '1, '1), 1, KIND_FINACK, '1);
    add_row(mk(OP_FINISH, '0, '0, '0), 1, KIND_FINACK, '0);
    add_row(mk(OP_CONNECT, PEER_A, '0, '0), 1, KIND_GO, PEER_A);
    add_row(mk(OP_CONNECT, PEER_B, '0, '0));
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_CONNECT, PEER_A, '1, '1), 1, KIND_GO, PEER_A);
    add_row(mk(OP_DATA, PEER_B, 31'd1, 16'd5));
    add_row(mk(OP_DATA, PEER_A, '1, 16'd9));
    add_row(mk(OP_DATA, PEER_A, 31'd0, '1));
    add_row(mk(OP_DATA, PEER_A, 31'd2, '0));
    add_row(mk(OP_DATA, PEER_A, 31'd2, 16'h1234));
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_DATA, PEER_A, 31'd32, 16'd77));
    add_row(mk(OP_FINISH, PEER_B, '0, '0), 1, KIND_FINACK, PEER_B);
    add_row(mk(OP_DATA, PEER_A, 31'd33, 16'd3));
    add_row(mk(OP_FINISH, PEER_A, '0, '0));
    add_row(mk(OP_CONNECT, '1, '0, '0), 1, KIND_GO, '1);
    add_row(mk(OP_DATA, '1, 31'd31, 16'hBEEF));
    add_row(mk(OP_DATA, '1, 31'd40, 16'd1));
    add_row(mk(OP_TIMER, '0, '0, '0));
    add_row(mk(OP_FINISH, '1, '0, '0));
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it);
      if (directed_rows[i].typed && (step_results.size() != 1 ||
          step_results[0].kind != directed_rows[i].kind ||
          step_results[0].reply_address != directed_rows[i].addr)) begin
        $display("%0t: row %0d expected kind %0d addr %h, model gives %0d results",
                 $time, i, directed_rows[i].kind, directed_rows[i].addr,
                 step_results.size());
        failed = 1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    srrw_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        failed = 1;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data_o);
          failed = 1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          send_pcts [4];
    int          recv_pcts [4];
    logic [7:0]  limits [4];
    send_pcts = '{0, 55, 0, 29};
    recv_pcts = '{0, 0, 55, 29};
    limits = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'd1};
    m_link = LINK_IDLE;
    m_peer = '0;
    m_base = '0;
    m_retries = '0;
    m_retry_limit = 8'd3;
    foreach (m_rcvd[i]) m_rcvd[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      write_retry_limit(limits[p]);
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 0) begin
        fork
          begin
            repeat (50) @(posedge clk_i);
            hold_off = 1;
            repeat (2000) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 108; n++) send_item(random_item());
    end
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
